[rtl/core/gdd_pkg.sv]
// Package for the Gregorian day difference unit: payload structs, controller
// command/status structs, calendar tables and constants.
// No dependencies.
package gdd_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DIFF_W  = 23;
   localparam int unsigned SERIAL_W = 23;
   localparam int unsigned QUOT_W  = 8;    // year / 100 for a 14-bit year

   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

   // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT, exact for y < 43690
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 23'd365;
   localparam logic [YEAR_W:0]     CENTURY = 15'd100;

   typedef struct packed {
      logic [DAY_W-1:0]   first_day;
      logic [MONTH_W-1:0] first_month;
      logic [YEAR_W-1:0]  first_year;
      logic [DAY_W-1:0]   second_day;
      logic [MONTH_W-1:0] second_month;
      logic [YEAR_W-1:0]  second_year;
      logic               include_end_day;
   } gdd_req_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] day_difference;
      logic                     invalid_date;
   } gdd_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic sel;        // 0: first date, 1: second date
      logic do_mul;     // year products
      logic do_leap;    // leap / century checks, partial sum
      logic do_sum;     // finish serial day number
      logic finish;     // load result register
   } gdd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_busy;   // result register holds a transfer not yet taken
   } gdd_sts_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         4'd2:                                       r = 5'd28;
         default:                                    r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/gdd_datapath.sv]
// Datapath: request register, shared date-to-serial converter, difference
// stage and result register. Depends on gdd_pkg.
module gdd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gdd_pkg::gdd_cmd_type cmd,
   output gdd_pkg::gdd_sts_type sts,
   input  gdd_pkg::gdd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gdd_pkg::gdd_rsp_type rsp_data
);

   gdd_pkg::gdd_req_type req_ff;

   logic [gdd_pkg::DAY_W-1:0]   cur_day;
   logic [gdd_pkg::MONTH_W-1:0] cur_month;
   logic [gdd_pkg::YEAR_W-1:0]  cur_year;

   logic [gdd_pkg::YEAR_W-1:0]   p_ff;
   logic [gdd_pkg::SERIAL_W-1:0] mul365_ff;
   logic [gdd_pkg::QUOT_W-1:0]   qy_ff;
   logic [gdd_pkg::PROD_W-1:0]   recip_prod;

   logic                         leap_ff, ok_ff;
   logic [gdd_pkg::QUOT_W-1:0]   qp_ff;
   logic [gdd_pkg::SERIAL_W-1:0] part_ff;
   logic                         div100, leap_in, ok_in;
   logic [gdd_pkg::DAY_W-1:0]    len;

   logic [gdd_pkg::SERIAL_W-1:0] serial_in;
   logic [gdd_pkg::SERIAL_W-1:0] n1_ff, n2_ff;
   logic                         v1_ff, v2_ff;

   logic [gdd_pkg::DIFF_W-1:0]   diff_raw, diff_adj;
   gdd_pkg::gdd_rsp_type         rsp_in, rsp_ff;
   logic                         rsp_valid_ff, rsp_valid_in;

   always_comb begin
      if (cmd.sel) begin
         cur_day   = req_ff.second_day;
         cur_month = req_ff.second_month;
         cur_year  = req_ff.second_year;
      end else begin
         cur_day   = req_ff.first_day;
         cur_month = req_ff.first_month;
         cur_year  = req_ff.first_year;
      end
   end

   assign recip_prod = gdd_pkg::PROD_W'(cur_year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);

   // leap year: y%4==0 and (y%100!=0 or (y/100)%4==0)
   always_comb begin
      div100  = ((gdd_pkg::YEAR_W+1)'(qy_ff) * gdd_pkg::CENTURY) == {1'b0, cur_year};
      leap_in = (cur_year[1:0] == 2'b00) && (!div100 || (qy_ff[1:0] == 2'b00));
      len     = gdd_pkg::month_length(cur_month);
      if ((cur_month == gdd_pkg::MONTH_FEB) && leap_in) begin
         len = gdd_pkg::FEB_LEAP_LEN;
      end
      ok_in = (cur_year != '0) && (cur_year <= gdd_pkg::YEAR_MAX) &&
              (cur_month != '0) && (cur_month <= gdd_pkg::MONTH_DEC) &&
              (cur_day != '0) && (cur_day <= len);
   end

   assign serial_in = part_ff - gdd_pkg::SERIAL_W'(qp_ff)
                      + gdd_pkg::SERIAL_W'(qp_ff >> 2)
                      + gdd_pkg::SERIAL_W'(gdd_pkg::days_before_month(cur_month))
                      + gdd_pkg::SERIAL_W'((cur_month > gdd_pkg::MONTH_FEB) && leap_ff)
                      + gdd_pkg::SERIAL_W'(cur_day);

   always_comb begin
      diff_raw = n2_ff - n1_ff;
      diff_adj = diff_raw;
      if (req_ff.include_end_day) begin
         if (n1_ff <= n2_ff) begin
            diff_adj = diff_raw + 1'b1;
         end else begin
            diff_adj = diff_raw - 1'b1;
         end
      end
      if (v1_ff && v2_ff) begin
         rsp_in.day_difference = $signed(diff_adj);
         rsp_in.invalid_date   = 1'b0;
      end else begin
         rsp_in.day_difference = '0;
         rsp_in.invalid_date   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.do_mul) begin
         p_ff      <= cur_year - 1'b1;
         mul365_ff <= gdd_pkg::SERIAL_W'(cur_year - 1'b1) * gdd_pkg::DAYS_PER_YEAR;
         qy_ff     <= recip_prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];
      end
      if (cmd.do_leap) begin
         leap_ff <= leap_in;
         ok_ff   <= ok_in;
         qp_ff   <= qy_ff - gdd_pkg::QUOT_W'(div100);   // (y-1)/100
         part_ff <= mul365_ff + gdd_pkg::SERIAL_W'(p_ff >> 2);
      end
      if (cmd.do_sum) begin
         if (cmd.sel) begin
            n2_ff <= serial_in;
            v2_ff <= ok_ff;
         end else begin
            n1_ff <= serial_in;
            v1_ff <= ok_ff;
         end
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

[rtl/core/gdd_controller.sv]
// Controller: sequences the shared converter over both dates, then the
// difference stage. Depends on gdd_pkg.
module gdd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gdd_pkg::gdd_sts_type sts,
   output gdd_pkg::gdd_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LEAP = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_DIFF = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       sel_ff, sel_in;

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.sel     = sel_ff;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_LEAP;
         end
         ST_LEAP: begin
            cmd.do_leap = 1'b1;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.do_sum = 1'b1;
            if (sel_ff) begin
               state_in = ST_DIFF;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DIFF: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

[rtl/core/gregorian_day_difference_unit.sv]
// Top level of the Gregorian day difference unit.
// Depends on gdd_pkg, gdd_controller and gdd_datapath.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data) carries two dates and the
//    include_end_day flag; a transfer happens when valid and ready are high.
//  - Response channel (rsp_valid/rsp_ready/rsp_data) returns the signed day
//    count from the first date to the second and an invalid_date flag; an
//    invalid date (bad day, month or year) gives a zero difference.
//  - Each date goes through one shared converter in three steps (year
//    products, leap/century check, serial sum), then one step forms the
//    difference and loads it into the result register, raising rsp_valid.
//  - A new request is taken only once the controller is back in idle, after
//    the two passes through the shared converter and the difference step.
//  - req_ready is high only while the controller is idle. The result sits in
//    an output register, so the next request is taken while the previous
//    result still waits; if rsp_ready stays low the controller holds in the
//    difference step until the register frees up.
//  - Synchronous active-high reset returns the controller to idle and drops
//    rsp_valid; no results are pending after reset.
module gregorian_day_difference_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gdd_pkg::gdd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gdd_pkg::gdd_rsp_type rsp_data
);

   gdd_pkg::gdd_cmd_type cmd;    // controller -> datapath
   gdd_pkg::gdd_sts_type sts;    // datapath -> controller

   gdd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gdd_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // an invalid date always comes back with a zero count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid_date |-> rsp_data.day_difference == '0)
      else $error("invalid date with nonzero difference");

   // controller is busy for the cycle after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // every request has a result waiting (rsp_valid) after its transfer
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##8 rsp_valid)
      else $error("result missing after request");
`endif

endmodule

[tb/sv/tb_gregorian_day_difference_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gregorian_day_difference_unit: a directed table
// and random date pairs, checked against a day-count predictor in this file.
// Depends on gdd_pkg and the unit's RTL.
module tb_gregorian_day_difference_unit;
   import gdd_pkg::*;

   localparam int CLOCK_HALF_NS    = 4;
   localparam int RESET_CYCLES     = 11;
   localparam int RANDOM_PER_PHASE = 430;
   localparam int TAIL_CYCLES      = 24;
   localparam int WATCHDOG_NS      = 8_000_000;
   localparam int unsigned LAST_YEAR = 9999;

   // One row of the directed table. When known is set the expected result is
   // typed into the row; otherwise the predictor supplies it.
   typedef struct packed {
      gdd_req_type req;
      bit          known;
      gdd_rsp_type rsp;
   } date_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gdd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gdd_rsp_type rsp_data;

   // Expected results, oldest first; pushed when a request transfer happens.
   gdd_rsp_type  pending_differences[$];
   date_row_type directed_rows[$];
   int unsigned  notable_years[$] = '{1, 2, 3, 4, 99, 100, 101, 399, 400, 401, 1600, 1700,
                                      1800, 1899, 1900, 2000, 2004, 2100, 2400, 9996, 9999};
   int          mismatch_count = 0;
   int          results_seen   = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   gregorian_day_difference_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // Only called with months 1..12.
   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
         2:           return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic bit real_date(int unsigned d, int unsigned m, int unsigned y);
      if (y < 1 || y > LAST_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= days_in_month(m, y);
   endfunction

   // Days counted from 1 Jan of year 1 (that day is 1).
   function automatic int day_number(int unsigned d, int unsigned m, int unsigned y);
      int          n;
      int unsigned p;
      int unsigned k;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (k = 1; k < m; k++) n += days_in_month(k, y);
      return n + d;
   endfunction

   function automatic gdd_rsp_type predict_difference(gdd_req_type r);
      gdd_rsp_type res;
      int          from_day;
      int          to_day;
      int          delta;
      res = '0;
      if (!real_date(r.first_day, r.first_month, r.first_year) ||
          !real_date(r.second_day, r.second_month, r.second_year)) begin
         res.invalid_date = 1'b1;
         return res;
      end
      from_day = day_number(r.first_day, r.first_month, r.first_year);
      to_day   = day_number(r.second_day, r.second_month, r.second_year);
      delta    = to_day - from_day;
      // end day widens the magnitude; equal dates count upward
      if (r.include_end_day) delta += (from_day <= to_day) ? 1 : -1;
      res.day_difference = DIFF_W'(delta);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic gdd_req_type make_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                                             int unsigned d2, int unsigned m2, int unsigned y2,
                                             bit end_day);
      gdd_req_type r;
      r.first_day       = DAY_W'(d1);
      r.first_month     = MONTH_W'(m1);
      r.first_year      = YEAR_W'(y1);
      r.second_day      = DAY_W'(d2);
      r.second_month    = MONTH_W'(m2);
      r.second_year     = YEAR_W'(y2);
      r.include_end_day = end_day;
      return r;
   endfunction

   function automatic void add_row(int unsigned d1, int unsigned m1, int unsigned y1,
                                   int unsigned d2, int unsigned m2, int unsigned y2,
                                   bit end_day, bit known, int diff, bit invalid);
      date_row_type row;
      row.req                = make_pair(d1, m1, y1, d2, m2, y2, end_day);
      row.known              = known;
      row.rsp.day_difference = DIFF_W'(diff);
      row.rsp.invalid_date   = invalid;
      directed_rows.push_back(row);
   endfunction

   function automatic int unsigned pick_year();
      if ($urandom_range(99) < 30)
         return notable_years[$urandom_range(notable_years.size() - 1)];
      return $urandom_range(LAST_YEAR, 1);
   endfunction

   // Month ends and first days get extra weight.
   function automatic int unsigned pick_day(int unsigned m, int unsigned y);
      case ($urandom_range(7))
         0:       return 1;
         1:       return days_in_month(m, y);
         default: return $urandom_range(days_in_month(m, y), 1);
      endcase
   endfunction

   function automatic gdd_req_type random_pair();
      gdd_req_type r;
      logic [63:0] noise;
      int unsigned kind;
      int unsigned d1, m1, y1, d2, m2, y2;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // raw bits: mostly invalid dates, reaches every field bit
         noise = {$urandom, $urandom};
         r     = noise[$bits(gdd_req_type)-1:0];
         return r;
      end
      y1 = pick_year();
      m1 = $urandom_range(12, 1);
      d1 = pick_day(m1, y1);
      if (kind < 40) begin
         // second date close to the first, either side
         y2 = y1 + $urandom_range(2) - 1;
         if (y2 < 1) y2 = 1;
         if (y2 > LAST_YEAR) y2 = LAST_YEAR;
         m2 = ($urandom_range(1) != 0) ? m1 : $urandom_range(12, 1);
      end else begin
         y2 = pick_year();
         m2 = $urandom_range(12, 1);
      end
      d2 = pick_day(m2, y2);
      // a few pairs get a day just past the end of its month
      if (kind < 18) begin
         if ($urandom_range(1) != 0) d1 = days_in_month(m1, y1) + 1;
         else                        d2 = days_in_month(m2, y2) + 1;
      end
      return make_pair(d1, m1, y1, d2, m2, y2, 1'($urandom_range(1)));
   endfunction

   // Offer one pair; the expectation is queued at the transfer edge.
   task automatic send_pair(input gdd_req_type pair, input bit known, input gdd_rsp_type typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (!req_ready);
      pending_differences.push_back(known ? typed : predict_difference(pair));
   endtask

   // Sender goes quiet until every queued result has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_differences.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, what);
      mismatch_count++;
   endtask

   task automatic check_result(input gdd_rsp_type got);
      gdd_rsp_type want;
      if (pending_differences.size() == 0) begin
         flag_mismatch($sformatf("unexpected transfer, diff %0d invalid %0b",
                                 got.day_difference, got.invalid_date));
      end else begin
         want = pending_differences.pop_front();
         if (got.day_difference !== want.day_difference)
            flag_mismatch($sformatf("day_difference %0d, want %0d",
                                    got.day_difference, want.day_difference));
         if (got.invalid_date !== want.invalid_date)
            flag_mismatch($sformatf("invalid_date %0b, want %0b",
                                    got.invalid_date, want.invalid_date));
      end
      results_seen++;
   endtask

   // Receiver: sample at the edge (pre-update values), then pick next rsp_ready.
   initial begin : response_side
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      int phase;
      int n;

      // Equal dates, with and without the end day.
      add_row( 1,  1,    1,  1,  1,    1, 0, 1, 0, 0);
      add_row( 1,  1,    1,  1,  1,    1, 1, 1, 1, 0);
      add_row(31, 12, 9999, 31, 12, 9999, 1, 1, 1, 0);
      // Full range, both directions; the later-first case with the end day
      // moves one further from zero.
      add_row( 1,  1,    1, 31, 12, 9999, 0, 1,  3652058, 0);
      add_row( 1,  1,    1, 31, 12, 9999, 1, 1,  3652059, 0);
      add_row(31, 12, 9999,  1,  1,    1, 0, 1, -3652058, 0);
      add_row(31, 12, 9999,  1,  1,    1, 1, 1, -3652059, 0);
      // Leap rules around century years: predictor rows.
      add_row(28,  2, 1900,  1,  3, 1900, 0, 0, 0, 0);
      add_row(28,  2, 2000,  1,  3, 2000, 1, 0, 0, 0);
      add_row(29,  2, 2024, 29,  2, 1600, 0, 0, 0, 0);
      add_row(31, 12, 2099,  1,  1, 2101, 0, 0, 0, 0);
      add_row( 1,  3, 2001, 28,  2, 2001, 1, 0, 0, 0);
      add_row(31, 12, 9999, 29,  2, 2000, 1, 0, 0, 0);
      // Invalid dates: zero difference, flag raised, end day ignored.
      add_row( 0,  1, 2000,  1,  1, 2000, 0, 1, 0, 1);
      add_row( 1,  1, 2000,  1,  0, 2000, 1, 1, 0, 1);
      add_row( 1, 13, 2000,  1,  1, 2000, 1, 1, 0, 1);
      add_row( 1,  1, 2000,  1, 15, 2000, 0, 1, 0, 1);
      add_row( 1,  1,    0,  1,  1, 2000, 0, 1, 0, 1);
      add_row( 1,  1, 2000,  1,  1, 10000, 1, 1, 0, 1);
      add_row(31, 15, 16383, 31, 12, 9999, 1, 1, 0, 1);
      add_row(31,  4, 2023,  1,  1, 2023, 0, 1, 0, 1);
      add_row( 1,  1, 1900, 29,  2, 1900, 1, 1, 0, 1);
      add_row(30,  2, 2000,  1,  1, 2000, 0, 1, 0, 1);
      add_row( 1,  1, 2100, 29,  2, 2100, 0, 1, 0, 1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 7;
      recv_stall_pct = 60;
      foreach (directed_rows[i])
         send_pair(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rsp);
      hold_until_drained();

      // Random pairs in three idling regimes: slow receiver, slow sender, none.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 7;  recv_stall_pct = 60; end
            1:       begin send_idle_pct = 60; recv_stall_pct = 7;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) send_pair(random_pair(), 1'b0, '0);
         hold_until_drained();
      end

      // Catch any stray transfer after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_gregorian_day_difference_unit: done, clean");
      else
         $display("tb_gregorian_day_difference_unit: done, errors");
      $finish;
   end

   // Hang guard: covers a stuck handshake or results that never arrive.
   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("tb_gregorian_day_difference_unit: done, errors");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/gdd_pkg.sv
rtl/core/gdd_datapath.sv
rtl/core/gdd_controller.sv
rtl/core/gregorian_day_difference_unit.sv
tb/sv/tb_gregorian_day_difference_unit.sv
